@@ hw/rtl/fmmu_pkg.sv @@
// Shared types and constants of the float matrix multiply unit.
`timescale 1ns / 1ps

package fmmu_pkg;

  // Float format constants
  localparam int unsigned FP_W = 32;
  localparam logic [FP_W-1:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [FP_W-1:0] FP_INF = 32'h7F80_0000;
  localparam logic [FP_W-1:0] FP_POS_ZERO = 32'h0000_0000;
  localparam logic [FP_W-1:0] FP_NEG_ZERO = 32'h8000_0000;

  // Configuration register file
  localparam int unsigned CFG_W = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COLS_B     = 2'd2
  } cfg_reg_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_left;
    logic wr_right;
    logic rd_en;
    logic fma_start;
    logic acc_clear;
    logic out_load;
    logic out_final;
  } fmmu_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic fma_done;
    logic out_free;
  } fmmu_status_t;

endpackage

@@ hw/rtl/fmmu_fma.sv @@
// Seven-stage single-precision fused multiply-add, round to nearest even.
`timescale 1ns / 1ps

module fmmu_fma import fmmu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [FP_W-1:0] a_i,
  input  logic [FP_W-1:0] b_i,
  input  logic [FP_W-1:0] c_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [FP_W-1:0] result_o
);

  // Index of the highest set bit, zero for an empty word
  function automatic logic [5:0] top_bit(input logic [62:0] v);
    logic [5:0] k;
    k = 6'd0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) k = 6'(i);
    end
    return k;
  endfunction

  logic [6:0] v_q, v_d;

  // ---------------- stage 0: unpack, specials, mantissa product
  logic       sa, sb, sc, sp;
  logic [7:0] xa, xb, xc, xa_e, xb_e, xc_e;
  logic [22:0] fa, fb, fc;
  logic       a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
  logic       s0_spec;
  logic [FP_W-1:0] s0_spec_val;
  logic [23:0] ma, mb, mc;
  logic [47:0] s0_mp;
  logic signed [11:0] s0_ep, s0_ec;

  always_comb begin
    sa = a_i[31];
    sb = b_i[31];
    sc = c_i[31];
    sp = sa ^ sb;
    xa = a_i[30:23];
    xb = b_i[30:23];
    xc = c_i[30:23];
    fa = a_i[22:0];
    fb = b_i[22:0];
    fc = c_i[22:0];
    a_nan = (&xa) && (|fa);
    b_nan = (&xb) && (|fb);
    c_nan = (&xc) && (|fc);
    a_inf = (&xa) && !(|fa);
    b_inf = (&xb) && !(|fb);
    c_inf = (&xc) && !(|fc);
    a_zero = !(|xa) && !(|fa);
    b_zero = !(|xb) && !(|fb);
    c_zero = !(|xc) && !(|fc);

    s0_spec = 1'b1;
    s0_spec_val = FP_QNAN;
    if (a_nan || b_nan || c_nan) begin
      s0_spec_val = FP_QNAN;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      s0_spec_val = FP_QNAN;
    end else if (a_inf || b_inf) begin
      if (c_inf && (sc != sp)) s0_spec_val = FP_QNAN;
      else s0_spec_val = {sp, FP_INF[30:0]};
    end else if (c_inf) begin
      s0_spec_val = c_i;
    end else if (a_zero || b_zero) begin
      if (c_zero) s0_spec_val = (sp && sc) ? FP_NEG_ZERO : FP_POS_ZERO;
      else s0_spec_val = c_i;
    end else begin
      s0_spec = 1'b0;
    end

    ma = {|xa, fa};
    mb = {|xb, fb};
    mc = {|xc, fc};
    xa_e = (|xa) ? xa : 8'd1;
    xb_e = (|xb) ? xb : 8'd1;
    xc_e = (|xc) ? xc : 8'd1;
    s0_mp = {24'b0, ma} * {24'b0, mb};
    s0_ep = $signed(12'(xa_e) + 12'(xb_e) - 12'd300);
    s0_ec = $signed(12'(xc_e) - 12'd150);
  end

  logic            s1_spec_q, s1_sp_q, s1_sc_q, s1_czero_q;
  logic [FP_W-1:0] s1_spec_val_q;
  logic [47:0]     s1_mp_q;
  logic [23:0]     s1_mc_q;
  logic signed [11:0] s1_ep_q, s1_ec_q;

  always_ff @(posedge clk_i) begin
    s1_spec_q     <= s0_spec;
    s1_spec_val_q <= s0_spec_val;
    s1_sp_q       <= sp;
    s1_sc_q       <= sc;
    s1_czero_q    <= c_zero;
    s1_mp_q       <= s0_mp;
    s1_mc_q       <= mc;
    s1_ep_q       <= s0_ep;
    s1_ec_q       <= s0_ec;
  end

  // ---------------- stage 1: normalize both operands to bit 61
  logic [5:0]  kp, kc, shp, shc;
  logic [61:0] s1_mpn, s1_mcn;
  logic signed [11:0] s1_epn, s1_ecn;

  always_comb begin
    kp = top_bit({15'b0, s1_mp_q});
    kc = top_bit({39'b0, s1_mc_q});
    shp = 6'd61 - kp;
    shc = 6'd61 - kc;
    s1_mpn = {14'b0, s1_mp_q} << shp;
    s1_mcn = {38'b0, s1_mc_q} << shc;
    s1_epn = s1_ep_q - $signed({6'b0, shp});
    s1_ecn = s1_ec_q - $signed({6'b0, shc});
  end

  logic            s2_spec_q, s2_sp_q, s2_sc_q, s2_czero_q;
  logic [FP_W-1:0] s2_spec_val_q;
  logic [61:0]     s2_mp_q, s2_mc_q;
  logic signed [11:0] s2_ep_q, s2_ec_q;

  always_ff @(posedge clk_i) begin
    s2_spec_q     <= s1_spec_q;
    s2_spec_val_q <= s1_spec_val_q;
    s2_sp_q       <= s1_sp_q;
    s2_sc_q       <= s1_sc_q;
    s2_czero_q    <= s1_czero_q;
    s2_mp_q       <= s1_mpn;
    s2_mc_q       <= s1_mcn;
    s2_ep_q       <= s1_epn;
    s2_ec_q       <= s1_ecn;
  end

  // ---------------- stage 2: order the addends and align the lesser one
  logic        p_big, s2_sbig, s2_sub;
  logic [61:0] s2_big, s2_sml, s2_al;
  logic [11:0] s2_d;
  logic signed [11:0] s2_ebig;
  logic [5:0]  s2_amt;

  always_comb begin
    p_big = s2_czero_q || (s2_ep_q > s2_ec_q) ||
            ((s2_ep_q == s2_ec_q) && (s2_mp_q >= s2_mc_q));
    s2_big  = p_big ? s2_mp_q : s2_mc_q;
    s2_sml  = p_big ? (s2_czero_q ? 62'b0 : s2_mc_q) : s2_mp_q;
    s2_ebig = p_big ? s2_ep_q : s2_ec_q;
    s2_d    = p_big ? 12'(s2_ep_q - s2_ec_q) : 12'(s2_ec_q - s2_ep_q);
    s2_sbig = p_big ? s2_sp_q : s2_sc_q;
    s2_sub  = s2_sp_q != s2_sc_q;
    s2_amt  = s2_d[5:0];
    if (s2_d >= 12'd62) begin
      s2_al = {61'b0, |s2_sml};
    end else begin
      s2_al = (s2_sml >> s2_amt) |
              {61'b0, |(s2_sml & ~({62{1'b1}} << s2_amt))};
    end
  end

  logic            s3_spec_q, s3_sbig_q, s3_sub_q;
  logic [FP_W-1:0] s3_spec_val_q;
  logic [61:0]     s3_big_q, s3_al_q;
  logic signed [11:0] s3_e_q;

  always_ff @(posedge clk_i) begin
    s3_spec_q     <= s2_spec_q;
    s3_spec_val_q <= s2_spec_val_q;
    s3_sbig_q     <= s2_sbig;
    s3_sub_q      <= s2_sub;
    s3_big_q      <= s2_big;
    s3_al_q       <= s2_al;
    s3_e_q        <= s2_ebig;
  end

  // ---------------- stage 3: add or subtract magnitudes
  logic [62:0] s3_sum;

  always_comb begin
    if (s3_sub_q) s3_sum = {1'b0, s3_big_q} - {1'b0, s3_al_q};
    else s3_sum = {1'b0, s3_big_q} + {1'b0, s3_al_q};
  end

  logic            s4_spec_q, s4_sign_q;
  logic [FP_W-1:0] s4_spec_val_q;
  logic [62:0]     s4_s_q;
  logic signed [11:0] s4_e_q;

  always_ff @(posedge clk_i) begin
    s4_spec_q     <= s3_spec_q;
    s4_spec_val_q <= s3_spec_val_q;
    s4_sign_q     <= s3_sbig_q;
    s4_s_q        <= s3_sum;
    s4_e_q        <= s3_e_q;
  end

  // ---------------- stage 4: pick the result exponent and shift amount
  logic [5:0] s4_k;
  logic signed [11:0] s4_traw, s4_t, s4_sh;

  always_comb begin
    s4_k = top_bit(s4_s_q);
    s4_traw = $signed({6'b0, s4_k}) + s4_e_q - 12'sd23;
    s4_t = (s4_traw < -12'sd149) ? -12'sd149 : s4_traw;
    s4_sh = s4_t - s4_e_q;
  end

  logic            s5_spec_q, s5_sign_q, s5_szero_q;
  logic [FP_W-1:0] s5_spec_val_q;
  logic [62:0]     s5_s_q;
  logic signed [11:0] s5_t_q, s5_sh_q;

  always_ff @(posedge clk_i) begin
    s5_spec_q     <= s4_spec_q;
    s5_spec_val_q <= s4_spec_val_q;
    s5_sign_q     <= s4_sign_q;
    s5_szero_q    <= !(|s4_s_q);
    s5_s_q        <= s4_s_q;
    s5_t_q        <= s4_t;
    s5_sh_q       <= s4_sh;
  end

  // ---------------- stage 5: shift to 24 bits and decide the rounding
  logic [11:0] s5_neg;
  logic [5:0]  s5_ramt;
  logic [62:0] s5_qr, s5_rem, s5_half;
  logic [24:0] s5_q;
  logic        s5_rup;

  always_comb begin
    s5_neg  = 12'(-s5_sh_q);
    s5_ramt = s5_sh_q[5:0];
    s5_qr   = s5_s_q >> s5_ramt;
    s5_rem  = s5_s_q & ~({63{1'b1}} << s5_ramt);
    s5_half = 63'b1 << (s5_ramt - 6'd1);
    if (s5_sh_q <= 12'sd0) begin
      s5_q   = s5_s_q[24:0] << s5_neg[4:0];
      s5_rup = 1'b0;
    end else if (s5_sh_q >= 12'sd64) begin
      s5_q   = 25'b0;
      s5_rup = 1'b0;
    end else begin
      s5_q   = s5_qr[24:0];
      s5_rup = (s5_rem > s5_half) || ((s5_rem == s5_half) && s5_qr[0]);
    end
  end

  logic            s6_spec_q, s6_sign_q, s6_szero_q, s6_rup_q;
  logic [FP_W-1:0] s6_spec_val_q;
  logic [24:0]     s6_q_q;
  logic signed [11:0] s6_t_q;

  always_ff @(posedge clk_i) begin
    s6_spec_q     <= s5_spec_q;
    s6_spec_val_q <= s5_spec_val_q;
    s6_sign_q     <= s5_sign_q;
    s6_szero_q    <= s5_szero_q;
    s6_rup_q      <= s5_rup;
    s6_q_q        <= s5_q;
    s6_t_q        <= s5_t_q;
  end

  // ---------------- stage 6: round up, renormalize, pack
  logic [24:0] s6_q, s6_q2;
  logic signed [11:0] s6_t2, s6_biased;
  logic [FP_W-1:0] s6_res;

  always_comb begin
    s6_q = s6_q_q + {24'b0, s6_rup_q};
    s6_q2 = s6_q[24] ? (s6_q >> 1) : s6_q;
    s6_t2 = s6_q[24] ? (s6_t_q + 12'sd1) : s6_t_q;
    s6_biased = s6_t2 + 12'sd150;
    if (s6_spec_q) begin
      s6_res = s6_spec_val_q;
    end else if (s6_szero_q) begin
      s6_res = FP_POS_ZERO;
    end else if (!(|s6_q)) begin
      s6_res = {s6_sign_q, 31'b0};
    end else if (!s6_q2[23]) begin
      s6_res = {s6_sign_q, 8'b0, s6_q2[22:0]};
    end else if (s6_biased >= 12'sd255) begin
      s6_res = {s6_sign_q, FP_INF[30:0]};
    end else begin
      s6_res = {s6_sign_q, s6_biased[7:0], s6_q2[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    result_o <= s6_res;
  end

  // Track the operation through the stages
  assign v_d = {v_q[5:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign busy_o = |v_q;
  assign done_o = v_q[6];

  a_fma_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##7 done_o)
    else $error("fma result not ready seven cycles after start");

endmodule

@@ hw/rtl/fmmu_datapath.sv @@
// Datapath: operand stores, accumulator, fused multiply-add and result register.
`timescale 1ns / 1ps

module fmmu_datapath import fmmu_pkg::*; #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fmmu_cmd_t                              cmd_i,
  output fmmu_status_t                           status_o,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     wr_addr_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     rd_left_addr_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     rd_right_addr_i,
  input  logic [FP_W-1:0]                        element_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [FP_W-1:0]                        product_element_o,
  output logic                                   final_flag_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

  logic [FP_W-1:0] left_mem [DEPTH];
  logic [FP_W-1:0] right_mem [DEPTH];
  logic [FP_W-1:0] left_rd_q, right_rd_q;
  logic [FP_W-1:0] acc_q;
  logic [FP_W-1:0] fma_res;
  logic            fma_busy, fma_done;
  logic            out_valid_q, out_valid_d;
  logic [FP_W-1:0] out_data_q;
  logic            out_final_q;

  // Write stores on input requests, read operands with registered data
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_left) left_mem[wr_addr_i] <= element_i;
    if (cmd_i.rd_en) left_rd_q <= left_mem[rd_left_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_right) right_mem[wr_addr_i] <= element_i;
    if (cmd_i.rd_en) right_rd_q <= right_mem[rd_right_addr_i];
  end

  fmmu_fma u_fma (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.fma_start),
    .a_i      (left_rd_q),
    .b_i      (right_rd_q),
    .c_i      (acc_q),
    .busy_o   (fma_busy),
    .done_o   (fma_done),
    .result_o (fma_res)
  );

  // Hold the running sum, clear it for each result element
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clear) acc_q <= FP_POS_ZERO;
    else if (fma_done) acc_q <= fma_res;
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q  <= acc_q;
      out_final_q <= cmd_i.out_final;
    end
  end

  assign status_o.fma_done = fma_done;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign product_element_o = out_data_q;
  assign final_flag_o      = out_final_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fma_start |-> !fma_busy)
    else $error("fma started while a previous operation is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten before its request was taken");

endmodule

@@ hw/rtl/fmmu_ctrl.sv @@
// Controller: configuration registers, load counter and multiply loop sequencer.
`timescale 1ns / 1ps

module fmmu_ctrl import fmmu_pkg::*; #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]               cfg_index_i,
  input  logic [CFG_W-1:0]                   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  output fmmu_cmd_t                          cmd_o,
  input  fmmu_status_t                       status_i,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_left_addr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_right_addr_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned CNT_W  = $clog2(2 * MAX_DIM * MAX_DIM + 1);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_DIM);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_MAC,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic [CFG_W-1:0]  rows_q, inner_q, cols_q;
  logic [CNT_W-1:0]  load_cnt_q;
  logic [IDX_W-1:0]  m_q, p_q, n_q;
  logic [ADDR_W-1:0] row_base_q, left_addr_q, right_addr_q;

  // Effective sizes clamped to one .. MAX_DIM
  function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > CFG_W'(MAX_DIM)) r = CFG_W'(MAX_DIM);
    return DIM_W'(r);
  endfunction

  logic [DIM_W-1:0] m_sz, n_sz, p_sz;
  logic [CNT_W-1:0] na, total, b_off;
  logic             in_accept, in_b, last_in;
  logic             m_last, p_last, n_last;

  always_comb begin
    m_sz = eff_size(rows_q);
    n_sz = eff_size(inner_q);
    p_sz = eff_size(cols_q);
    na = CNT_W'(m_sz) * CNT_W'(n_sz);
    total = na + CNT_W'(n_sz) * CNT_W'(p_sz);
    b_off = load_cnt_q - na;
    in_accept = in_valid_i && (state_q == ST_LOAD);
    in_b = load_cnt_q >= na;
    last_in = (load_cnt_q + CNT_W'(1)) == total;
    m_last = m_q == IDX_W'(m_sz - DIM_W'(1));
    p_last = p_q == IDX_W'(p_sz - DIM_W'(1));
    n_last = n_q == IDX_W'(n_sz - DIM_W'(1));
  end

  // Drive datapath commands
  always_comb begin
    cmd_o.wr_left   = in_accept && !in_b;
    cmd_o.wr_right  = in_accept && in_b;
    cmd_o.rd_en     = state_q == ST_READ;
    cmd_o.fma_start = state_q == ST_MAC;
    cmd_o.out_load  = (state_q == ST_EMIT) && status_i.out_free;
    cmd_o.out_final = m_last && p_last;
    cmd_o.acc_clear = (in_accept && last_in) || cmd_o.out_load;
  end

  assign wr_addr_o       = in_b ? b_off[ADDR_W-1:0] : load_cnt_q[ADDR_W-1:0];
  assign rd_left_addr_o  = left_addr_q;
  assign rd_right_addr_o = right_addr_q;
  assign in_stall_o      = state_q != ST_LOAD;
  assign cfg_ready_o     = 1'b1;

  // Sequence loads, multiply-adds and result hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      rows_q       <= CFG_SIZE_RESET;
      inner_q      <= CFG_SIZE_RESET;
      cols_q       <= CFG_SIZE_RESET;
      load_cnt_q   <= '0;
      m_q          <= '0;
      p_q          <= '0;
      n_q          <= '0;
      row_base_q   <= '0;
      left_addr_q  <= '0;
      right_addr_q <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_accept) begin
            if (last_in) begin
              load_cnt_q   <= '0;
              m_q          <= '0;
              p_q          <= '0;
              n_q          <= '0;
              row_base_q   <= '0;
              left_addr_q  <= '0;
              right_addr_q <= '0;
              state_q      <= ST_READ;
            end else begin
              load_cnt_q <= load_cnt_q + CNT_W'(1);
            end
          end
        end
        ST_READ: begin
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (status_i.fma_done) begin
            if (n_last) begin
              state_q <= ST_EMIT;
            end else begin
              n_q          <= n_q + IDX_W'(1);
              left_addr_q  <= left_addr_q + ADDR_W'(1);
              right_addr_q <= right_addr_q + ADDR_W'(p_sz);
              state_q      <= ST_READ;
            end
          end
        end
        ST_EMIT: begin
          if (status_i.out_free) begin
            n_q <= '0;
            if (p_last) begin
              p_q <= '0;
              if (m_last) begin
                state_q <= ST_LOAD;
              end else begin
                m_q          <= m_q + IDX_W'(1);
                row_base_q   <= row_base_q + ADDR_W'(n_sz);
                left_addr_q  <= row_base_q + ADDR_W'(n_sz);
                right_addr_q <= '0;
                state_q      <= ST_READ;
              end
            end else begin
              p_q          <= p_q + IDX_W'(1);
              left_addr_q  <= row_base_q;
              right_addr_q <= ADDR_W'(p_q) + ADDR_W'(1);
              state_q      <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase

      // Register writes restart the load
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ROWS_A: begin
            rows_q     <= cfg_data_i;
            load_cnt_q <= '0;
          end
          CFG_INNER_SIZE: begin
            inner_q    <= cfg_data_i;
            load_cnt_q <= '0;
          end
          CFG_COLS_B: begin
            cols_q     <= cfg_data_i;
            load_cnt_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_stall_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_in) |=> in_stall_o)
    else $error("input still open after the last operand request");

endmodule

@@ hw/rtl/float_matrix_multiply_unit.sv @@
// Top level of the single-precision matrix multiply unit.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_stall_o  element_i (A row-major, then B)
//   out      out        out_valid_o/stall_i    product_element_o, final_flag_o
//
// Loading accepts one operand request per cycle; the stores are written at once.
// Each multiply-add runs a store read, an issue step and the 7-stage FMA unit;
// none starts before the last is done, as the accumulate chain runs through the
// single FMA unit. Each of the M*P elements takes N multiply-adds and an emit.
// Reset needs no clearing pass; sizes come up as 8 by 8 by 8.
// Output stalls hold the sequencer in its emit step; input is taken again as
// soon as the last result sits in the output register.
`timescale 1ns / 1ps

module float_matrix_multiply_unit import fmmu_pkg::*; #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FP_W-1:0]      element_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FP_W-1:0]      product_element_o,
  output logic                 final_flag_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  fmmu_cmd_t         cmd;
  fmmu_status_t      status;
  logic [ADDR_W-1:0] wr_addr, rd_left_addr, rd_right_addr;

  fmmu_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_o           (cmd),
    .status_i        (status),
    .wr_addr_o       (wr_addr),
    .rd_left_addr_o  (rd_left_addr),
    .rd_right_addr_o (rd_right_addr)
  );

  fmmu_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .wr_addr_i         (wr_addr),
    .rd_left_addr_i    (rd_left_addr),
    .rd_right_addr_i   (rd_right_addr),
    .element_i         (element_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .product_element_o (product_element_o),
    .final_flag_o      (final_flag_o)
  );

endmodule
